/* src/eac_pkg.sv */
// Package for the rotation axis canonicalizer: axis index type and the
// column permutation table. No dependencies.
package eac_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_PERMS = 6;

  typedef logic [1:0] axis_t;
  typedef logic [2:0] perm_idx_t;

  // Column permutations, in the order in which they are scored.
  localparam axis_t PERM_TABLE [NUM_PERMS][NUM_AXES] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd2, 2'd1},
    '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0}
  };

endpackage

/* src/ellipsoid_axis_canonicalize.sv */
// Rotation axis canonicalizer top level: picks the column permutation and
// signs that maximize the trace. Depends on eac_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | rot_rR_cC (signed), radius_K (unsigned)
//   output  | out_valid,out_stall| out_rR_cC (signed), out_radius_K
//
// One item per cycle while out_stall is low; an accepted item passes
// through the input register, then the trace compare logic, then the
// result register.
// Reset (rst, synchronous) clears both valid flags; payload is not reset.
// A stalled result holds; the input register still accepts an item when
// the result register is empty or is being taken in the same cycle.
module ellipsoid_axis_canonicalize
  import eac_pkg::*;
#(
  parameter int ENTRY_WIDTH  = 16,
  parameter int RADIUS_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r0_c0,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r1_c0,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r2_c0,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r0_c1,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r1_c1,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r2_c1,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r0_c2,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r1_c2,
  input  logic signed [ENTRY_WIDTH-1:0]  rot_r2_c2,
  input  logic        [RADIUS_WIDTH-1:0] radius_0,
  input  logic        [RADIUS_WIDTH-1:0] radius_1,
  input  logic        [RADIUS_WIDTH-1:0] radius_2,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ENTRY_WIDTH-1:0]  out_r0_c0,
  output logic signed [ENTRY_WIDTH-1:0]  out_r1_c0,
  output logic signed [ENTRY_WIDTH-1:0]  out_r2_c0,
  output logic signed [ENTRY_WIDTH-1:0]  out_r0_c1,
  output logic signed [ENTRY_WIDTH-1:0]  out_r1_c1,
  output logic signed [ENTRY_WIDTH-1:0]  out_r2_c1,
  output logic signed [ENTRY_WIDTH-1:0]  out_r0_c2,
  output logic signed [ENTRY_WIDTH-1:0]  out_r1_c2,
  output logic signed [ENTRY_WIDTH-1:0]  out_r2_c2,
  output logic        [RADIUS_WIDTH-1:0] out_radius_0,
  output logic        [RADIUS_WIDTH-1:0] out_radius_1,
  output logic        [RADIUS_WIDTH-1:0] out_radius_2
);

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic        [RADIUS_WIDTH-1:0] radius_t;
  typedef logic        [ENTRY_WIDTH:0]    score_t;

  localparam entry_t ENTRY_MIN = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};
  localparam entry_t ENTRY_MAX = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};

  function automatic entry_t neg_sat(input entry_t x);
    return (x == ENTRY_MIN) ? ENTRY_MAX : -x;
  endfunction

  function automatic entry_t abs_sat(input entry_t x);
    return (x < 0) ? neg_sat(x) : x;
  endfunction

  // Matrices are held column-major: mat[col][row].
  entry_t  mat [NUM_AXES][NUM_AXES];
  radius_t rad [NUM_AXES];
  logic    mat_valid;

  entry_t  res_mat [NUM_AXES][NUM_AXES];
  radius_t res_rad [NUM_AXES];

  entry_t    sel_mat [NUM_AXES][NUM_AXES];
  radius_t   sel_rad [NUM_AXES];
  score_t    score   [NUM_PERMS];
  score_t    lead_score;
  perm_idx_t best_perm;
  axis_t     src;
  logic      keep;
  logic      res_adv;

  assign res_adv  = !out_valid || !out_stall;
  assign in_stall = mat_valid && !res_adv;

  // Signs are independent per column, so the best sign code keeps a column
  // exactly when its diagonal entry is positive (a zero diagonal ties and
  // the earlier, negated code wins). Each permutation then scores the sum
  // of saturated magnitudes of its diagonal sources.
  always_comb begin
    for (int p = 0; p < NUM_PERMS; p++) begin
      score[p] = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        score[p] = score[p] + {1'b0, abs_sat(mat[PERM_TABLE[p][k]][k])};
      end
    end
    lead_score = score[0];
    best_perm  = '0;
    for (int p = 1; p < NUM_PERMS; p++) begin
      if (score[p] > lead_score) begin
        lead_score = score[p];
        best_perm  = perm_idx_t'(p);
      end
    end
    src  = '0;
    keep = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      src  = PERM_TABLE[best_perm][k];
      keep = mat[src][k] > 0;
      for (int r = 0; r < NUM_AXES; r++) begin
        sel_mat[k][r] = keep ? mat[src][r] : neg_sat(mat[src][r]);
      end
      sel_rad[k] = rad[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        mat_valid <= in_valid;
      end
      if (res_adv) begin
        out_valid <= mat_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mat[0][0] <= rot_r0_c0;
      mat[0][1] <= rot_r1_c0;
      mat[0][2] <= rot_r2_c0;
      mat[1][0] <= rot_r0_c1;
      mat[1][1] <= rot_r1_c1;
      mat[1][2] <= rot_r2_c1;
      mat[2][0] <= rot_r0_c2;
      mat[2][1] <= rot_r1_c2;
      mat[2][2] <= rot_r2_c2;
      rad[0]    <= radius_0;
      rad[1]    <= radius_1;
      rad[2]    <= radius_2;
    end
    if (res_adv && mat_valid) begin
      res_mat <= sel_mat;
      res_rad <= sel_rad;
    end
  end

  assign out_r0_c0    = res_mat[0][0];
  assign out_r1_c0    = res_mat[0][1];
  assign out_r2_c0    = res_mat[0][2];
  assign out_r0_c1    = res_mat[1][0];
  assign out_r1_c1    = res_mat[1][1];
  assign out_r2_c1    = res_mat[1][2];
  assign out_r0_c2    = res_mat[2][0];
  assign out_r1_c2    = res_mat[2][1];
  assign out_r2_c2    = res_mat[2][2];
  assign out_radius_0 = res_rad[0];
  assign out_radius_1 = res_rad[1];
  assign out_radius_2 = res_rad[2];

endmodule

/* bench/ellipsoid_axis_canonicalize_tb.sv */
// Self-checking bench for ellipsoid_axis_canonicalize: directed and random
// rotation matrices, random idling on both channels. Depends on eac_pkg.
`timescale 1ns / 100ps

module ellipsoid_axis_canonicalize_tb;
  import eac_pkg::*;

  localparam int EW = 16;
  localparam int RW = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_ITEMS = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS = 60;

  typedef logic [EW-1:0] entry_t;
  typedef logic [RW-1:0] radius_t;

  localparam entry_t ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam entry_t ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};

  // ent[c][r] is row r of column c; rad[c] is the radius of column c.
  typedef struct packed {
    entry_t  [2:0][2:0] ent;
    radius_t [2:0]      rad;
  } axes_t;

  class canon_scoreboard;
    axes_t pending[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    function entry_t negate_clamp(entry_t x);
      if (x == ENTRY_MIN) return ENTRY_MAX;
      return -x;
    endfunction

    // Scores all 48 signed column permutations by trace; first best wins.
    function axes_t canonical_pick(axes_t item);
      axes_t best;
      axes_t cand;
      int    score;
      int    top;
      bit    have;
      int    src;
      best = '0;
      have = 1'b0;
      top  = 0;
      for (int p = 0; p < NUM_PERMS; p++) begin
        for (int s = 0; s < 8; s++) begin
          score = 0;
          for (int c = 0; c < 3; c++) begin
            src = int'(PERM_TABLE[p][c]);
            for (int r = 0; r < 3; r++) begin
              cand.ent[c][r] = s[c] ? item.ent[src][r] : negate_clamp(item.ent[src][r]);
            end
            cand.rad[c] = item.rad[src];
            score += int'($signed(cand.ent[c][c]));
          end
          if (!have || score > top) begin
            have = 1'b1;
            top  = score;
            best = cand;
          end
        end
      end
      return best;
    endfunction

    function void note_input(axes_t item);
      pending.push_back(canonical_pick(item));
    endfunction

    function void check_result(axes_t got);
      axes_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with no expected item waiting", $time);
        return;
      end
      want = pending.pop_front();
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (got.ent[c][r] !== want.ent[c][r]) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_r%0d_c%0d expected %0d actual %0d", $time, r, c,
                       $signed(want.ent[c][r]), $signed(got.ent[c][r]));
          end
        end
        if (got.rad[c] !== want.rad[c]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: out_radius_%0d expected %0d actual %0d", $time, c,
                     want.rad[c], got.rad[c]);
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    out_stall = 1'b0;
  axes_t   stim = '0;
  logic    in_stall;
  logic    out_valid;
  entry_t  res_ent [3][3];
  radius_t res_rad [3];

  bit      quiet = 1'b0;
  int      idle_count = 0;
  canon_scoreboard board = new();

  ellipsoid_axis_canonicalize #(
    .ENTRY_WIDTH (EW),
    .RADIUS_WIDTH(RW)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rot_r0_c0   (stim.ent[0][0]),
    .rot_r1_c0   (stim.ent[0][1]),
    .rot_r2_c0   (stim.ent[0][2]),
    .rot_r0_c1   (stim.ent[1][0]),
    .rot_r1_c1   (stim.ent[1][1]),
    .rot_r2_c1   (stim.ent[1][2]),
    .rot_r0_c2   (stim.ent[2][0]),
    .rot_r1_c2   (stim.ent[2][1]),
    .rot_r2_c2   (stim.ent[2][2]),
    .radius_0    (stim.rad[0]),
    .radius_1    (stim.rad[1]),
    .radius_2    (stim.rad[2]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_r0_c0   (res_ent[0][0]),
    .out_r1_c0   (res_ent[0][1]),
    .out_r2_c0   (res_ent[0][2]),
    .out_r0_c1   (res_ent[1][0]),
    .out_r1_c1   (res_ent[1][1]),
    .out_r2_c1   (res_ent[1][2]),
    .out_r0_c2   (res_ent[2][0]),
    .out_r1_c2   (res_ent[2][1]),
    .out_r2_c2   (res_ent[2][2]),
    .out_radius_0(res_rad[0]),
    .out_radius_1(res_rad[1]),
    .out_radius_2(res_rad[2])
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both handshakes are sampled here, before this edge's updates land.
  always @(posedge clk) begin
    axes_t got;
    if (rst) begin
      idle_count <= 0;
    end else begin
      if (in_valid && !in_stall) board.note_input(stim);
      if (out_valid && !out_stall) begin
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) got.ent[c][r] = res_ent[c][r];
          got.rad[c] = res_rad[c];
        end
        board.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
        $display("ellipsoid_axis_canonicalize test failed");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Receiver stalls in bursts; none once the run is winding down.
  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 12)) @(posedge clk);
      end
    end
  end

  function automatic entry_t random_entry_extreme();
    case ($urandom_range(0, 6))
      0: return ENTRY_MIN;
      1: return ENTRY_MAX;
      2: return entry_t'(ENTRY_MIN + 1);
      3: return '0;
      4: return '1;
      5: return entry_t'(1);
      default: return entry_t'($urandom);
    endcase
  endfunction

  // Signed permutation matrix with magnitude mag; column c carries its
  // large entry in row PERM_TABLE[p][c], negated where neg[c] is set.
  function automatic axes_t perm_matrix(int p, int mag, bit [2:0] neg);
    axes_t m;
    m = '0;
    for (int c = 0; c < 3; c++)
      m.ent[c][int'(PERM_TABLE[p][c])] = neg[c] ? entry_t'(-mag) : entry_t'(mag);
    return m;
  endfunction

  function automatic axes_t random_item();
    axes_t m;
    int    kind;
    int    p;
    int    mag;
    kind = $urandom_range(0, 9);
    p    = $urandom_range(0, NUM_PERMS - 1);
    m    = '0;
    if (kind <= 2) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) m.ent[c][r] = entry_t'($urandom);
    end else if (kind <= 6) begin
      // Near-rotation: a signed permutation plus small noise.
      mag = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(16384, 32767);
      m = perm_matrix(p, mag, 3'($urandom));
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          m.ent[c][r] = m.ent[c][r] + entry_t'(int'($urandom_range(0, 4000)) - 2000);
    end else if (kind <= 8) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) m.ent[c][r] = random_entry_extreme();
    end else begin
      // Equal magnitudes everywhere make many candidates tie.
      mag = $urandom_range(0, 3);
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          m.ent[c][r] = $urandom_range(0, 1) ? entry_t'(mag) : entry_t'(-mag);
    end
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 5))
        0: m.rad[c] = '0;
        1: m.rad[c] = '1;
        default: m.rad[c] = radius_t'($urandom);
      endcase
    end
    return m;
  endfunction

  task automatic send_item(axes_t item, bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    stim     <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    axes_t directed[$];
    axes_t m;
    bit    calm;

    m = '0;
    directed.push_back(m);
    m.rad = {radius_t'('1), radius_t'('1), radius_t'('1)};
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) m.ent[c][r] = ENTRY_MAX;
    directed.push_back(m);
    m.rad = {radius_t'(3), radius_t'(2), radius_t'(1)};
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) m.ent[c][r] = ENTRY_MIN;
    directed.push_back(m);
    // Every permutation, with a different sign pattern and both extremes.
    for (int p = 0; p < NUM_PERMS; p++) begin
      m = perm_matrix(p, 32767, 3'(p + 1));
      m.rad = {radius_t'(16'h8000), radius_t'(16'h0001), radius_t'(p * 1000)};
      directed.push_back(m);
      m = perm_matrix(p, 32768, 3'(7 - p));
      m.rad = {radius_t'(p), radius_t'('1), radius_t'(0)};
      directed.push_back(m);
    end
    // Most negative entries on the diagonal, most positive elsewhere.
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) m.ent[c][r] = (c == r) ? ENTRY_MIN : ENTRY_MAX;
    directed.push_back(m);
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        m.ent[c][r] = ((c + r) % 2 != 0) ? entry_t'(16'h5555) : entry_t'(16'haaaa);
    m.rad = {radius_t'(16'h5555), radius_t'(16'haaaa), radius_t'(16'hffff)};
    directed.push_back(m);
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        m.ent[c][r] = ((c + r) % 2 != 0) ? entry_t'(16'haaaa) : entry_t'(16'h5555);
    m.rad = {radius_t'(16'haaaa), radius_t'(16'h5555), radius_t'(0)};
    directed.push_back(m);
    // Unit entries: every candidate trace lies in a narrow band of ties.
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) m.ent[c][r] = entry_t'(1);
    directed.push_back(m);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i], 1'b1);
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) drain_results();
      quiet = (k >= RANDOM_ITEMS - QUIET_ITEMS);
      calm  = ((k / 60) % 4 == 3);
      send_item(random_item(), !quiet && !calm);
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ellipsoid_axis_canonicalize test passed");
    end else begin
      $display("ellipsoid_axis_canonicalize test failed");
    end
    $finish;
  end

endmodule
